>>> hdl/osc_pkg.sv
package osc_pkg;

   // Port word widths, fixed by the request and response formats
   localparam int LIMIT_W = 17;
   localparam int COUNT_W = 17;

endpackage

>>> hdl/odd_only_prime_sieve_counter.sv
// Odd-only prime sieve counter.
// Request: pulse start with req_limit while busy is low; the word is taken at
// that clock edge. Limits above MAX_LIMIT are treated as MAX_LIMIT.
// Response: rsp_valid is high for exactly one cycle with rsp_prime_count, the
// number of primes <= limit. The receiver cannot stall; the word is gone
// after that cycle. busy is low again in the cycle rsp_valid is high, so a
// new request can be issued alongside the response.
// A limit of 0 or 1 is answered in the next cycle. Otherwise, with
// U = (limit-1)/2 bitmap entries, the block marks each multiple of each
// sieving prime, reads and checks each entry up to the last sieving prime,
// and then counts all U entries. All work goes through one bitmap memory
// with one read port and one write port.
// Reset: synchronous, active high. After reset the bitmap is swept to zero,
// one entry per cycle (MAX_LIMIT/2 entries, 32768 by default) with busy high.
// The counting pass clears each entry as it reads it, so every request
// starts on a clean bitmap with no further sweep.
module odd_only_prime_sieve_counter #(
   parameter int MAX_LIMIT = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [osc_pkg::LIMIT_W-1:0] req_limit,
   output logic                        rsp_valid,
   output logic [osc_pkg::COUNT_W-1:0] rsp_prime_count
);

   localparam int DEPTH = MAX_LIMIT / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int UW    = AW + 1;
   localparam int PW    = UW + 2;
   localparam int IW    = AW + 4;
   localparam int NW    = $clog2(MAX_LIMIT + 1);
   localparam int CW    = (NW > osc_pkg::LIMIT_W) ? NW : osc_pkg::LIMIT_W;
   localparam int TW    = (UW + 1 > osc_pkg::COUNT_W) ? UW + 1 : osc_pkg::COUNT_W;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_MARK     = 3'd2;
   localparam logic [2:0] ST_SCAN_RD  = 3'd3;
   localparam logic [2:0] ST_SCAN_CHK = 3'd4;
   localparam logic [2:0] ST_COUNT    = 3'd5;
   localparam logic [2:0] ST_DRAIN    = 3'd6;

   // bitmap: entry i stands for odd number 2*i+3, 1 = composite
   logic          map_mem [DEPTH];
   logic          map_rd_ff;
   logic [AW-1:0] map_raddr;
   logic [AW-1:0] map_waddr;
   logic          map_we;
   logic          map_wdata;

   logic [2:0]    state_ff, state_in;
   logic [UW-1:0] used_ff, used_in;
   logic [UW-1:0] scan_ff, scan_in;
   logic [UW-1:0] sq_idx_ff, sq_idx_in;
   logic [UW-1:0] idx_ff, idx_in;
   logic [UW-1:0] cnt_ff, cnt_in;
   logic [UW-1:0] total_ff, total_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [osc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CW-1:0] lim_ext;
   logic [CW-1:0] lim_sat;
   logic [CW-1:0] lim_half;
   logic [PW-1:0] prime;
   logic [PW-1:0] idx_step;
   logic [UW-1:0] scan_next;
   logic [IW-1:0] sq_step;
   logic [IW-1:0] sq_sum;
   logic [UW-1:0] sq_next;
   logic [TW-1:0] total_p1;

   // request limit, saturated, and its bitmap size
   assign lim_ext  = CW'(req_limit);
   assign lim_sat  = (lim_ext > CW'(MAX_LIMIT)) ? CW'(MAX_LIMIT) : lim_ext;
   assign lim_half = (lim_sat - CW'(1)) >> 1;

   // current sieving prime 2*s+3 and next marking position
   assign prime    = PW'({scan_ff, 1'b1}) + PW'(2);
   assign idx_step = PW'(idx_ff) + prime;

   // square index (p*p-3)/2 tracked incrementally: grows by 4s+8 per step,
   // clamped at the bitmap size once it passes it
   assign scan_next = scan_ff + UW'(1);
   assign sq_step   = IW'({scan_ff, 2'b00}) + IW'(8);
   assign sq_sum    = IW'(sq_idx_ff) + sq_step;
   assign sq_next   = (sq_sum >= IW'(used_ff)) ? used_ff : sq_sum[UW-1:0];

   assign total_p1  = TW'(total_ff) + TW'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      sq_idx_in    = sq_idx_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      pend_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      map_raddr    = scan_next[AW-1:0];
      map_waddr    = cnt_ff[AW-1:0];
      map_we       = 1'b0;
      map_wdata    = 1'b0;

      if (pend_ff && !map_rd_ff) begin
         total_in = total_ff + UW'(1);
      end

      case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = cnt_ff[AW-1:0];
            cnt_in    = cnt_ff + UW'(1);
            if (cnt_ff == UW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (lim_ext < CW'(2)) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
               end else begin
                  used_in   = lim_half[UW-1:0];
                  scan_in   = '0;
                  sq_idx_in = UW'(3);
                  idx_in    = UW'(3);
                  total_in  = '0;
                  state_in  = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            if (idx_ff < used_ff) begin
               map_we    = 1'b1;
               map_waddr = idx_ff[AW-1:0];
               map_wdata = 1'b1;
               if (idx_step < PW'(used_ff)) begin
                  idx_in = idx_step[UW-1:0];
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            scan_in   = scan_next;
            sq_idx_in = sq_next;
            map_raddr = scan_next[AW-1:0];
            if (scan_next >= used_ff) begin
               cnt_in   = '0;
               state_in = ST_COUNT;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (map_rd_ff) begin
               state_in = ST_SCAN_RD;
            end else if (sq_idx_ff < used_ff) begin
               idx_in   = sq_idx_ff;
               state_in = ST_MARK;
            end else begin
               cnt_in   = '0;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            // read each entry and clear it behind the read
            map_raddr = cnt_ff[AW-1:0];
            map_waddr = cnt_ff[AW-1:0];
            if (cnt_ff < used_ff) begin
               map_we  = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + UW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = total_p1[osc_pkg::COUNT_W-1:0];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      used_ff      <= used_in;
      scan_ff      <= scan_in;
      sq_idx_ff    <= sq_idx_in;
      idx_ff       <= idx_in;
      total_ff     <= total_in;
      rsp_count_ff <= rsp_count_in;
   end

   // bitmap memory, registered read, old data on same-address write
   always_ff @(posedge clock) begin
      map_rd_ff <= map_mem[map_raddr];
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

endmodule

>>> hdl/osc_checker.sv
module osc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [osc_pkg::LIMIT_W-1:0] req_limit,
   input logic                        rsp_valid,
   input logic [osc_pkg::COUNT_W-1:0] rsp_prime_count
);

   // reset starts the bitmap sweep with no response pending
   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("not busy or stray response after reset");

   // a real request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_limit >= osc_pkg::LIMIT_W'(2)) |=> busy && !rsp_valid)
      else $error("request with limit >= 2 not held busy");

   // limits 0 and 1 answer at once with zero
   a_tiny_limit: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_limit < osc_pkg::LIMIT_W'(2)) |=>
         rsp_valid && rsp_prime_count == '0 && !busy)
      else $error("limit below two not answered with zero");

   // a response word only shows when the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

endmodule

bind odd_only_prime_sieve_counter osc_checker u_osc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_limit       (req_limit),
   .rsp_valid       (rsp_valid),
   .rsp_prime_count (rsp_prime_count)
);
